// ===== hw/rtl/sds_pkg.sv =====
// package for the scan disk scheduler: payload structs, register map, widths
// used by scan_disk_scheduler_top; no dependencies
`timescale 1ns / 1ps

package sds_pkg;

  localparam int MAX_REQUESTS_DEF = 32;
  localparam int TRACK_W          = 16;
  localparam int TRACK_COUNT_W    = 17;
  localparam int SUM_W            = 18;
  localparam int PADDR_W          = 4;
  localparam int PDATA_W          = 32;

  localparam logic [TRACK_COUNT_W-1:0] TRACK_COUNT_RST = 17'd200;

  localparam logic [1:0] REG_START_HEAD  = 2'd0;
  localparam logic [1:0] REG_TRACK_COUNT = 2'd1;
  localparam logic [1:0] REG_SWEEP_UP    = 2'd2;

  typedef struct packed {
    logic [TRACK_W-1:0] request_track;
    logic               batch_end;
  } sds_req_t;

  typedef struct packed {
    logic [TRACK_W-1:0] visit_track;
    logic [SUM_W-1:0]   movement_total;
    logic               run_last;
  } sds_res_t;

endpackage

// ===== hw/rtl/scan_disk_scheduler_top.sv =====
// scan disk scheduler top level: apb registers, sorted request store, sequencer
// depends on sds_pkg and sds_ram
//
//   channel   | handshake                         | payload
//   ----------+-----------------------------------+---------------------
//   request   | start && !busy                    | request (sds_req_t)
//   result    | result_valid, one cycle, no stall | result (sds_res_t)
//   config    | psel && penable && pwrite         | paddr, pwdata, prdata
//
// a request keeps busy through S_INS_RD and S_INS_CMP for each store entry it moves past;
// a request dropped by a full store leaves busy low unless it closes the batch
// closing a batch adds S_FIND_RD and S_FIND_CMP for each entry below the head,
// then S_VIS_RD and S_VIS_OUT per visit, with S_END_OUT for the end track visit
// rst is synchronous; the store needs no clearing, entries past the count are
// never read; results cannot be held off and leave one per strobe
`timescale 1ns / 1ps

module scan_disk_scheduler_top #(
  parameter int MAX_REQUESTS = sds_pkg::MAX_REQUESTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  sds_pkg::sds_req_t              request,
  output logic                           result_valid,
  output sds_pkg::sds_res_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sds_pkg::PADDR_W-1:0]    paddr,
  input  logic [sds_pkg::PDATA_W-1:0]    pwdata,
  output logic [sds_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  import sds_pkg::*;

  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_RD   = 8'b0000_0010,
    S_INS_CMP  = 8'b0000_0100,
    S_FIND_RD  = 8'b0000_1000,
    S_FIND_CMP = 8'b0001_0000,
    S_VIS_RD   = 8'b0010_0000,
    S_VIS_OUT  = 8'b0100_0000,
    S_END_OUT  = 8'b1000_0000
  } state_t;

  // configuration registers
  logic [TRACK_W-1:0]       start_head;
  logic [TRACK_COUNT_W-1:0] track_count;
  logic                     sweep_up;
  logic [1:0]               reg_sel;
  logic                     cfg_wr;

  // sequencer registers
  state_t             state, state_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      below, below_next;
  logic               leg, leg_next;
  logic [TRACK_W-1:0] req, req_next;
  logic               pend_end, pend_end_next;
  logic [TRACK_W-1:0] head, head_next;
  logic [SUM_W-1:0]   sum, sum_next;
  sds_res_t           result_next;
  logic               result_valid_next;

  // store port
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [TRACK_W-1:0] wdata, rdata;

  // shared compare and movement unit
  logic [TRACK_W-1:0] last_trk, head_init, in_trk, cmp_b, vis_trk, delta;
  logic               cmp_gt, cmp_lt, cur_up, accept;
  logic [CW-1:0]      idx_m1, idx_p1;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;

  always_comb begin
    if (track_count == '0) begin
      last_trk = '0;
    end else if (track_count[TRACK_COUNT_W-1]) begin
      last_trk = '1;
    end else begin
      last_trk = track_count[TRACK_W-1:0] - 1'b1;
    end
  end

  assign head_init = (start_head > last_trk) ? last_trk : start_head;
  assign in_trk    = (request.request_track > last_trk) ? last_trk
                                                        : request.request_track;

  assign cmp_b  = (state == S_INS_CMP) ? req : head;
  assign cmp_gt = rdata > cmp_b;
  assign cmp_lt = rdata < cmp_b;

  assign cur_up  = leg ? !sweep_up : sweep_up;
  assign vis_trk = (state == S_END_OUT) ? (sweep_up ? last_trk : '0) : rdata;
  assign delta   = (vis_trk > head) ? (vis_trk - head) : (head - vis_trk);
  assign idx_m1  = idx - 1'b1;
  assign idx_p1  = idx + 1'b1;

  always_comb begin
    unique case (reg_sel)
      REG_START_HEAD:  prdata = PDATA_W'(start_head);
      REG_TRACK_COUNT: prdata = PDATA_W'(track_count);
      REG_SWEEP_UP:    prdata = PDATA_W'(sweep_up);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    idx_next          = idx;
    below_next        = below;
    leg_next          = leg;
    req_next          = req;
    pend_end_next     = pend_end;
    head_next         = head;
    sum_next          = sum;
    result_next       = result;
    result_valid_next = 1'b0;
    we                = 1'b0;
    waddr             = idx[AW-1:0];
    wdata             = req;
    raddr             = idx_m1[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          req_next      = in_trk;
          pend_end_next = request.batch_end;
          idx_next      = cnt;
          if (cnt < MAX_CNT) begin
            state_next = S_INS_RD;
          end else if (request.batch_end) begin
            state_next = S_FIND_RD;
            head_next  = head_init;
            sum_next   = '0;
            below_next = '0;
          end
        end
      end
      S_INS_RD: begin
        if (idx == '0) begin
          we       = 1'b1;
          cnt_next = cnt + 1'b1;
          if (pend_end) begin
            state_next = S_FIND_RD;
            head_next  = head_init;
            sum_next   = '0;
            below_next = '0;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (cmp_gt) begin
          wdata      = rdata;
          idx_next   = idx_m1;
          state_next = S_INS_RD;
        end else begin
          cnt_next = cnt + 1'b1;
          if (pend_end) begin
            state_next = S_FIND_RD;
            head_next  = head_init;
            sum_next   = '0;
            below_next = '0;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_FIND_RD: begin
        raddr = below[AW-1:0];
        if (below == cnt) begin
          state_next = S_VIS_RD;
          idx_next   = below;
          leg_next   = 1'b0;
        end else begin
          state_next = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (cmp_lt) begin
          below_next = below + 1'b1;
          state_next = S_FIND_RD;
        end else begin
          state_next = S_VIS_RD;
          idx_next   = below;
          leg_next   = 1'b0;
        end
      end
      S_VIS_RD: begin
        raddr = cur_up ? idx[AW-1:0] : idx_m1[AW-1:0];
        if ((cur_up && idx == cnt) || (!cur_up && idx == '0)) begin
          if (leg) begin
            state_next = S_IDLE;
            cnt_next   = '0;
            sum_next   = '0;
          end else begin
            state_next = S_END_OUT;
          end
        end else begin
          state_next = S_VIS_OUT;
        end
      end
      S_VIS_OUT: begin
        head_next                  = vis_trk;
        sum_next                   = sum + SUM_W'(delta);
        result_valid_next          = 1'b1;
        result_next.visit_track    = vis_trk;
        result_next.movement_total = sum + SUM_W'(delta);
        idx_next                   = cur_up ? idx_p1 : idx_m1;
        result_next.run_last       = leg && ((cur_up && idx_p1 == cnt) ||
                                             (!cur_up && idx == CW'(1)));
        if (result_next.run_last) begin
          state_next = S_IDLE;
          cnt_next   = '0;
          sum_next   = '0;
        end else begin
          state_next = S_VIS_RD;
        end
      end
      S_END_OUT: begin
        head_next                  = vis_trk;
        sum_next                   = sum + SUM_W'(delta);
        result_valid_next          = 1'b1;
        result_next.visit_track    = vis_trk;
        result_next.movement_total = sum + SUM_W'(delta);
        result_next.run_last       = sweep_up ? (below == '0) : (below == cnt);
        idx_next                   = below;
        leg_next                   = 1'b1;
        if (result_next.run_last) begin
          state_next = S_IDLE;
          cnt_next   = '0;
          sum_next   = '0;
        end else begin
          state_next = S_VIS_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      head         <= '0;
      sum          <= '0;
      result_valid <= 1'b0;
      start_head   <= '0;
      track_count  <= TRACK_COUNT_RST;
      sweep_up     <= 1'b1;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      head         <= head_next;
      sum          <= sum_next;
      result_valid <= result_valid_next;
      if (cfg_wr) begin
        unique case (reg_sel)
          REG_START_HEAD:  start_head  <= pwdata[TRACK_W-1:0];
          REG_TRACK_COUNT: track_count <= pwdata[TRACK_COUNT_W-1:0];
          REG_SWEEP_UP:    sweep_up    <= pwdata[0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    below    <= below_next;
    leg      <= leg_next;
    req      <= req_next;
    pend_end <= pend_end_next;
    result   <= result_next;
  end

  sds_ram #(
    .WIDTH (TRACK_W),
    .DEPTH (MAX_REQUESTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== hw/rtl/sds_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module sds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
